FILE: hw/rtl/tbc_pkg.sv
// Shared constants for the triangle barycentric coordinate unit.
package tbc_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int WFRAC_BITS_DEF = 16;
  localparam int W_BITS = 32;
  localparam int Q_BITS = 33;
  localparam int THR_BITS = 33;
  localparam int SIDE_OK = 0;
  localparam int SIDE_NEG0 = 1;
  localparam int SIDE_NEG1 = 2;
  localparam int SIDE_OVF0 = 3;
  localparam int SIDE_OVF1 = 4;
  localparam int SIDE_W = 5;
endpackage

FILE: hw/rtl/triangle_barycentric_coords_unit.sv
// Top level of the triangle barycentric coordinate unit.
// Takes one request per cycle while in_stall is low and returns its three
// Q15.16 weights and the nondegenerate flag through five setup stages
// (differences, products, sums, magnitudes, threshold compare), a chain of
// 33 divider cells that each retire one quotient bit of both weights, and two
// output stages. Each stage holds its request while the next one is full, so
// bubbles close up and the block keeps taking requests while a result waits,
// until every stage is full. The threshold register is written through cfg_valid.
module triangle_barycentric_coords_unit import tbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = WFRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [THR_BITS-1:0]          cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] vert0_x,
  input  logic signed [COORD_BITS-1:0] vert0_y,
  input  logic signed [COORD_BITS-1:0] vert1_x,
  input  logic signed [COORD_BITS-1:0] vert1_y,
  input  logic signed [COORD_BITS-1:0] vert2_x,
  input  logic signed [COORD_BITS-1:0] vert2_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [W_BITS-1:0]     weight_0,
  output logic signed [W_BITS-1:0]     weight_1,
  output logic signed [W_BITS-1:0]     weight_2,
  output logic                         nondegenerate
);
  localparam int SW = 2 * (COORD_BITS + 1) + 1;
  localparam int RW = SW + 1;

  logic [THR_BITS-1:0] degenerate_threshold;
  logic front_ready;
  logic              lv [Q_BITS+1];
  logic              lr [Q_BITS+1];
  logic [RW-1:0]     lrem0 [Q_BITS+1];
  logic [RW-1:0]     lrem1 [Q_BITS+1];
  logic [Q_BITS-1:0] lnum0 [Q_BITS+1];
  logic [Q_BITS-1:0] lnum1 [Q_BITS+1];
  logic [Q_BITS-1:0] lq0 [Q_BITS+1];
  logic [Q_BITS-1:0] lq1 [Q_BITS+1];
  logic [SW-1:0]     lden [Q_BITS+1];
  logic [SIDE_W-1:0] lside [Q_BITS+1];

  assign cfg_ready = 1'b1;
  assign in_stall = !front_ready;
  assign lq0[0] = '0;
  assign lq1[0] = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      degenerate_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      degenerate_threshold <= cfg_data;
    end
  end

  tbc_front #(.COORD_BITS(COORD_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_front (
    .clk, .rst,
    .in_valid, .in_ready(front_ready),
    .px(point_x), .py(point_y), .ax(vert0_x), .ay(vert0_y),
    .bx(vert1_x), .by(vert1_y), .cx(vert2_x), .cy(vert2_y),
    .thr(degenerate_threshold),
    .out_valid(lv[0]), .out_ready(lr[0]),
    .rem0(lrem0[0]), .rem1(lrem1[0]), .num0(lnum0[0]), .num1(lnum1[0]),
    .den(lden[0]), .side(lside[0])
  );

  for (genvar i = 0; i < Q_BITS; i++) begin : g_cell
    tbc_cell #(.DEN_W(SW)) u_cell (
      .clk, .rst,
      .in_valid(lv[i]), .in_ready(lr[i]),
      .rin0(lrem0[i]), .rin1(lrem1[i]), .nin0(lnum0[i]), .nin1(lnum1[i]),
      .qin0(lq0[i]), .qin1(lq1[i]), .din(lden[i]), .sin(lside[i]),
      .out_valid(lv[i+1]), .out_ready(lr[i+1]),
      .rout0(lrem0[i+1]), .rout1(lrem1[i+1]), .nout0(lnum0[i+1]), .nout1(lnum1[i+1]),
      .qout0(lq0[i+1]), .qout1(lq1[i+1]), .dout(lden[i+1]), .sout(lside[i+1])
    );
  end

  tbc_back #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_back (
    .clk, .rst,
    .in_valid(lv[Q_BITS]), .in_ready(lr[Q_BITS]),
    .q0(lq0[Q_BITS]), .q1(lq1[Q_BITS]), .sin(lside[Q_BITS]),
    .out_valid, .out_ready(!out_stall),
    .weight_0, .weight_1, .weight_2, .nondegenerate
  );

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !nondegenerate |-> weight_0 == '0 && weight_1 == '0 && weight_2 == '0)
    else $error("degenerate result with nonzero weights");
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |-> !in_stall)
    else $error("input stalled while pipeline drains");
endmodule

FILE: hw/rtl/tbc_front.sv
// Front pipeline: differences, products, sums, magnitudes, divider setup.
module tbc_front import tbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = WFRAC_BITS_DEF,
  localparam int DW = COORD_BITS + 1,
  localparam int PW = 2 * DW,
  localparam int SW = PW + 1,
  localparam int RW = SW + 1,
  localparam int NW = SW + WEIGHT_FRAC_BITS,
  localparam int CW = (SW > THR_BITS) ? SW : THR_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic [THR_BITS-1:0]          thr,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [RW-1:0]                rem0,
  output logic [RW-1:0]                rem1,
  output logic [Q_BITS-1:0]            num0,
  output logic [Q_BITS-1:0]            num1,
  output logic [SW-1:0]                den,
  output logic [SIDE_W-1:0]            side
);
  logic v1, v2, v3, v4;
  logic a1, a2, a3, a4, a5;
  logic signed [DW-1:0] d0x, d0y, d1x, d1y, dpx, dpy;
  logic signed [PW-1:0] pd0, pd1, pa0, pa1, pb0, pb1;
  logic signed [SW-1:0] sdet, sn0, sn1;
  logic [SW-1:0] mdet, mn0, mn1;
  logic ndet, nn0, nn1;
  logic [NW-1:0] f0, f1;

  assign a5 = !out_valid || out_ready;
  assign a4 = !v4 || a5;
  assign a3 = !v3 || a4;
  assign a2 = !v2 || a3;
  assign a1 = !v1 || a2;
  assign in_ready = a1;

  assign f0 = {mn0, {WEIGHT_FRAC_BITS{1'b0}}};
  assign f1 = {mn1, {WEIGHT_FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a1) v1 <= in_valid;
      if (a2) v2 <= v1;
      if (a3) v3 <= v2;
      if (a4) v4 <= v3;
      if (a5) out_valid <= v4;
    end
    if (a1) begin
      d0x <= {ax[COORD_BITS-1], ax} - {cx[COORD_BITS-1], cx};
      d0y <= {ay[COORD_BITS-1], ay} - {cy[COORD_BITS-1], cy};
      d1x <= {bx[COORD_BITS-1], bx} - {cx[COORD_BITS-1], cx};
      d1y <= {by[COORD_BITS-1], by} - {cy[COORD_BITS-1], cy};
      dpx <= {px[COORD_BITS-1], px} - {cx[COORD_BITS-1], cx};
      dpy <= {py[COORD_BITS-1], py} - {cy[COORD_BITS-1], cy};
    end
    if (a2) begin
      pd0 <= d0x * d1y;
      pd1 <= d0y * d1x;
      pa0 <= dpx * d1y;
      pa1 <= dpy * d1x;
      pb0 <= d0x * dpy;
      pb1 <= d0y * dpx;
    end
    if (a3) begin
      sdet <= {pd0[PW-1], pd0} - {pd1[PW-1], pd1};
      sn0 <= {pa0[PW-1], pa0} - {pa1[PW-1], pa1};
      sn1 <= {pb0[PW-1], pb0} - {pb1[PW-1], pb1};
    end
    if (a4) begin
      mdet <= sdet[SW-1] ? -sdet : sdet;
      mn0 <= sn0[SW-1] ? -sn0 : sn0;
      mn1 <= sn1[SW-1] ? -sn1 : sn1;
      ndet <= sdet[SW-1];
      nn0 <= sn0[SW-1];
      nn1 <= sn1[SW-1];
    end
    if (a5) begin
      side[SIDE_OK] <= CW'(mdet) > CW'(thr);
      side[SIDE_NEG0] <= nn0 ^ ndet;
      side[SIDE_NEG1] <= nn1 ^ ndet;
      side[SIDE_OVF0] <= (f0 >> Q_BITS) >= NW'(mdet);
      side[SIDE_OVF1] <= (f1 >> Q_BITS) >= NW'(mdet);
      rem0 <= RW'(f0 >> Q_BITS);
      rem1 <= RW'(f1 >> Q_BITS);
      num0 <= f0[Q_BITS-1:0];
      num1 <= f1[Q_BITS-1:0];
      den <= mdet;
    end
  end
endmodule

FILE: hw/rtl/tbc_cell.sv
// Divider cell: one quotient bit for both weight numerators.
module tbc_cell import tbc_pkg::*; #(
  parameter int DEN_W = 35,
  localparam int RW = DEN_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RW-1:0]     rin0,
  input  logic [RW-1:0]     rin1,
  input  logic [Q_BITS-1:0] nin0,
  input  logic [Q_BITS-1:0] nin1,
  input  logic [Q_BITS-1:0] qin0,
  input  logic [Q_BITS-1:0] qin1,
  input  logic [DEN_W-1:0]  din,
  input  logic [SIDE_W-1:0] sin,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RW-1:0]     rout0,
  output logic [RW-1:0]     rout1,
  output logic [Q_BITS-1:0] nout0,
  output logic [Q_BITS-1:0] nout1,
  output logic [Q_BITS-1:0] qout0,
  output logic [Q_BITS-1:0] qout1,
  output logic [DEN_W-1:0]  dout,
  output logic [SIDE_W-1:0] sout
);
  logic adv;
  logic [RW-1:0] t0, t1;
  logic ge0, ge1;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign t0 = {rin0[RW-2:0], nin0[Q_BITS-1]};
  assign t1 = {rin1[RW-2:0], nin1[Q_BITS-1]};
  assign ge0 = t0 >= {1'b0, din};
  assign ge1 = t1 >= {1'b0, din};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      rout0 <= ge0 ? t0 - {1'b0, din} : t0;
      rout1 <= ge1 ? t1 - {1'b0, din} : t1;
      nout0 <= {nin0[Q_BITS-2:0], 1'b0};
      nout1 <= {nin1[Q_BITS-2:0], 1'b0};
      qout0 <= {qin0[Q_BITS-2:0], ge0};
      qout1 <= {qin1[Q_BITS-2:0], ge1};
      dout <= din;
      sout <= sin;
    end
  end
endmodule

FILE: hw/rtl/tbc_back.sv
// Back end: signed saturation of the quotients and third weight.
module tbc_back import tbc_pkg::*; #(
  parameter int WEIGHT_FRAC_BITS = WFRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [Q_BITS-1:0]        q0,
  input  logic [Q_BITS-1:0]        q1,
  input  logic [SIDE_W-1:0]        sin,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [W_BITS-1:0] weight_0,
  output logic signed [W_BITS-1:0] weight_1,
  output logic signed [W_BITS-1:0] weight_2,
  output logic                     nondegenerate
);
  localparam logic [W_BITS-1:0] W_MAX = {1'b0, {(W_BITS-1){1'b1}}};
  localparam logic [W_BITS-1:0] W_MIN = {1'b1, {(W_BITS-1){1'b0}}};

  logic v1, a1, a2;
  logic ok1;
  logic [W_BITS-1:0] w0, w1;
  logic [W_BITS+1:0] s;

  function automatic logic [W_BITS-1:0] sat_q(input logic [Q_BITS-1:0] q,
                                              input logic neg, input logic ovf);
    logic big;
    big = ovf || q[Q_BITS-1];
    if (!neg) begin
      sat_q = (big || q[W_BITS-1]) ? W_MAX : q[W_BITS-1:0];
    end else begin
      sat_q = (big || (q[W_BITS-1] && q[W_BITS-2:0] != '0)) ? W_MIN : -q[W_BITS-1:0];
    end
  endfunction

  assign a2 = !out_valid || out_ready;
  assign a1 = !v1 || a2;
  assign in_ready = a1;
  assign s = (W_BITS+2)'(1) << WEIGHT_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a1) v1 <= in_valid;
      if (a2) out_valid <= v1;
    end
    if (a1) begin
      ok1 <= sin[SIDE_OK];
      w0 <= sin[SIDE_OK] ? sat_q(q0, sin[SIDE_NEG0], sin[SIDE_OVF0]) : '0;
      w1 <= sin[SIDE_OK] ? sat_q(q1, sin[SIDE_NEG1], sin[SIDE_OVF1]) : '0;
    end
  end

  logic [W_BITS+1:0] sum;
  assign sum = s - {{2{w0[W_BITS-1]}}, w0} - {{2{w1[W_BITS-1]}}, w1};

  always_ff @(posedge clk) begin
    if (a2) begin
      weight_0 <= w0;
      weight_1 <= w1;
      nondegenerate <= ok1;
      if (!ok1) begin
        weight_2 <= '0;
      end else if (sum[W_BITS+1:W_BITS-1] == 3'b000 || sum[W_BITS+1:W_BITS-1] == 3'b111) begin
        weight_2 <= sum[W_BITS-1:0];
      end else begin
        weight_2 <= sum[W_BITS+1] ? W_MIN : W_MAX;
      end
    end
  end
endmodule

FILE: tb/testbench.sv
// Testbench for the triangle barycentric coordinate unit: directed and random requests.
module testbench;
  import tbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 16;
  localparam int WF = 16;
  localparam int LATENCY = 40;
  localparam int N_RANDOM = 1650;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CB-1:0] px, py, ax, ay, bx, by, cx, cy;
  } tri_req_t;

  typedef struct packed {
    logic signed [W_BITS-1:0] w0, w1, w2;
    logic ok;
  } weights_t;

  typedef struct {
    tri_req_t req;
    logic [THR_BITS-1:0] thr;
    logic has_exp;
    weights_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [THR_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] point_x = '0, point_y = '0, vert0_x = '0, vert0_y = '0;
  logic signed [CB-1:0] vert1_x = '0, vert1_y = '0, vert2_x = '0, vert2_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [W_BITS-1:0] weight_0, weight_1, weight_2;
  logic nondegenerate;

  logic [THR_BITS-1:0] thr_shadow = '0;
  weights_t pending_weights[$];
  int errors = 0;
  int n_results = 0;
  int n_nondegen = 0;
  longint cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  triangle_barycentric_coords_unit uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y), .vert0_x(vert0_x), .vert0_y(vert0_y),
    .vert1_x(vert1_x), .vert1_y(vert1_y), .vert2_x(vert2_x), .vert2_y(vert2_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .weight_0(weight_0), .weight_1(weight_1), .weight_2(weight_2),
    .nondegenerate(nondegenerate)
  );

  function automatic longint clamp_weight(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // restoring fixed-point divide with capped quotient
  function automatic longint scaled_quotient(longint num, longint den);
    logic neg;
    longint unsigned un, ud, q, r;
    neg = (num < 0) != (den < 0);
    un = abs64(num);
    ud = abs64(den);
    q = un / ud;
    r = un % ud;
    if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
    for (int i = 0; i < WF; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ud) begin
        r = r - ud;
        q = q | 1;
      end
      if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
    end
    return clamp_weight(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic weights_t barycentric_weights(tri_req_t t, logic [THR_BITS-1:0] thr);
    weights_t w;
    longint d0x, d0y, d1x, d1y, dpx, dpy, det, a, b;
    d0x = longint'(t.ax) - t.cx;  d0y = longint'(t.ay) - t.cy;
    d1x = longint'(t.bx) - t.cx;  d1y = longint'(t.by) - t.cy;
    dpx = longint'(t.px) - t.cx;  dpy = longint'(t.py) - t.cy;
    det = d0x * d1y - d0y * d1x;
    w = '0;
    if (abs64(det) > longint'(thr)) begin
      a = scaled_quotient(dpx * d1y - dpy * d1x, det);
      b = scaled_quotient(d0x * dpy - d0y * dpx, det);
      w.w0 = a[31:0];
      w.w1 = b[31:0];
      a = clamp_weight((64'sd1 << WF) - a - b);
      w.w2 = a[31:0];
      w.ok = 1'b1;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    weights_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{weight_0, weight_1, weight_2, nondegenerate};
      if (pending_weights.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_weights.pop_front();
        if (got.w0 !== want.w0) begin
          $display("%0t: weight_0 exp %h got %h", $time, want.w0, got.w0); errors++;
        end
        if (got.w1 !== want.w1) begin
          $display("%0t: weight_1 exp %h got %h", $time, want.w1, got.w1); errors++;
        end
        if (got.w2 !== want.w2) begin
          $display("%0t: weight_2 exp %h got %h", $time, want.w2, got.w2); errors++;
        end
        if (got.ok !== want.ok) begin
          $display("%0t: nondegenerate exp %b got %b", $time, want.ok, got.ok); errors++;
        end
        n_results++;
        if (got.ok) n_nondegen++;
      end
    end
  end

  // output backpressure
  initial begin
    int hold;
    @(negedge rst);
    while (1) begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic write_threshold(logic [THR_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    thr_shadow = v;
  endtask

  task automatic drain();
    while (pending_weights.size() != 0) @(posedge clk);
  endtask

  task automatic send_request(tri_req_t t, logic chk, weights_t ew);
    int gap;
    weights_t pred;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    {point_x, point_y, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y} <= t;
    in_valid <= 1'b1;
    pred = barycentric_weights(t, thr_shadow);
    if (chk && pred !== ew) begin
      $display("%0t: table row exp %h predictor %h", $time, ew, pred);
      errors++;
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_weights.push_back(pred);
  endtask

  function automatic logic signed [CB-1:0] rand_coord(int spread);
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return $signed(16'($urandom_range(0, 2 * spread) - spread));
    endcase
  endfunction

  row_t table_rows[$];
  localparam logic signed [CB-1:0] ONE = 16'sh0100;
  localparam logic signed [CB-1:0] MX = 16'sh7fff;
  localparam logic signed [CB-1:0] MN = 16'sh8000;

  initial begin
    tri_req_t t;
    weights_t z;
    int span;
    z = '0;
    // unit right triangle: point at each vertex, hypotenuse midpoint, outside
    table_rows.push_back('{'{ONE, 0, ONE, 0, 0, ONE, 0, 0}, 0, 1,
                           '{32'sh10000, 0, 0, 1'b1}});
    table_rows.push_back('{'{0, ONE, ONE, 0, 0, ONE, 0, 0}, 0, 1,
                           '{0, 32'sh10000, 0, 1'b1}});
    table_rows.push_back('{'{0, 0, ONE, 0, 0, ONE, 0, 0}, 0, 1,
                           '{0, 0, 32'sh10000, 1'b1}});
    table_rows.push_back('{'{16'sh0080, 16'sh0080, ONE, 0, 0, ONE, 0, 0}, 0, 1,
                           '{32'sh8000, 32'sh8000, 0, 1'b1}});
    table_rows.push_back('{'{MN, MX, ONE, 0, 0, ONE, 0, 0}, 0, 0, z});
    // degenerate: all zero, collinear
    table_rows.push_back('{'{MX, MN, 0, 0, 0, 0, 0, 0}, 0, 1, z});
    table_rows.push_back('{'{ONE, ONE, ONE, ONE, MX, MX, MN, MN}, 0, 0, z});
    // extremes: huge weights, saturation, tiny det
    table_rows.push_back('{'{MX, MX, 16'sh0001, 0, 0, 16'sh0001, 0, 0}, 0, 0, z});
    table_rows.push_back('{'{MN, MN, 16'sh0001, 0, 0, 16'sh0001, MX, MX}, 0, 0, z});
    table_rows.push_back('{'{MX, MN, MX, MN, MN, MX, 0, MN}, 0, 0, z});
    table_rows.push_back('{'{MN, MX, MN, MN, MX, MX, MX, MN}, 0, 0, z});
    table_rows.push_back('{'{0, 0, MX, 0, 0, MX, MN, MN}, 0, 0, z});
    // threshold just below / at det = 1 and det = 0x10000, then a full-scale threshold
    table_rows.push_back('{'{0, 0, 16'sh0001, 0, 0, 16'sh0001, 0, 0}, 0, 0, z});
    table_rows.push_back('{'{0, 0, 16'sh0001, 0, 0, 16'sh0001, 0, 0}, 1, 1, z});
    table_rows.push_back('{'{ONE, 0, ONE, 0, 0, ONE, 0, 0}, 33'h0_0001_0000, 1, z});
    table_rows.push_back('{'{ONE, 0, ONE, 0, 0, ONE, 0, 0}, 33'h0_0000_ffff, 1,
                           '{32'sh10000, 0, 0, 1'b1}});
    table_rows.push_back('{'{MX, MX, MX, MN, MN, MX, MN, MN}, 33'h1_ffff_ffff, 1, z});
    table_rows.push_back('{'{MX, MX, MX, MN, MN, MX, MN, MN}, 0, 0, z});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i]) begin
      if (i == 0 || table_rows[i].thr != thr_shadow) begin
        in_valid <= 1'b0;
        drain();
        write_threshold(table_rows[i].thr);
      end
      send_request(table_rows[i].req, table_rows[i].has_exp, table_rows[i].exp);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 300 == 0) begin
        in_valid <= 1'b0;
        drain();
        case ((n / 300) % 4)
          0: write_threshold('0);
          1: write_threshold(33'($urandom_range(0, 32'h0010_0000)));
          2: write_threshold({1'b0, $urandom()});
          default: write_threshold({$urandom_range(0, 1) == 1, $urandom()});
        endcase
      end
      span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 2048);
      t.px = rand_coord(span); t.py = rand_coord(span);
      t.ax = rand_coord(span); t.ay = rand_coord(span);
      t.bx = rand_coord(span); t.by = rand_coord(span);
      t.cx = rand_coord(span); t.cy = rand_coord(span);
      if ($urandom_range(0, 15) == 0) begin
        t.bx = t.ax; t.by = t.ay;
      end
      // send each request after a random gap, sometimes none
      send_request(t, 1'b0, z);
    end
    in_valid <= 1'b0;
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d results (%0d nondegenerate) over %0d table rows and random triangles",
             n_results, n_nondegen, table_rows.size());
    $display("Thresholds swept from zero to full scale with random stalls on both sides");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/tbc_pkg.sv
hw/rtl/tbc_front.sv
hw/rtl/tbc_cell.sv
hw/rtl/tbc_back.sv
hw/rtl/triangle_barycentric_coords_unit.sv
tb/testbench.sv
